@@ rtl/akh_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// akh_pkg
// Shared constants, codes and controller/datapath interface types for the
// k-mer histogram block.
// ----------------------------------------------------------------------------
package akh_pkg;

  // sizing
  localparam int MAX_KMER_LENGTH = 8;
  localparam int COUNT_BITS      = 32;
  localparam int CODE_BITS       = 2 * MAX_KMER_LENGTH;
  localparam int TABLE_DEPTH     = 1 << CODE_BITS;
  localparam int CURSOR_BITS     = CODE_BITS + 1;
  localparam int FILL_BITS       = $clog2(MAX_KMER_LENGTH + 1);

  // port widths
  localparam int LEN_BITS        = 4;
  localparam int CFG_INDEX_BITS  = 1;
  localparam int CFG_DATA_BITS   = 4;
  localparam int ACTION_BITS     = 2;
  localparam int CHAR_BITS       = 8;
  localparam int KMER_CODE_BITS  = 16;
  localparam int KMER_COUNT_BITS = 32;
  localparam int SAT_CMP_BITS    =
    (COUNT_BITS > KMER_COUNT_BITS) ? COUNT_BITS : KMER_COUNT_BITS;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_KMER_LENGTH = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ANCHOR_ALL  = 1'b1;

  // register reset values
  localparam logic [LEN_BITS-1:0] KMER_LENGTH_RESET = 4'd3;
  localparam logic                ANCHOR_ALL_RESET  = 1'b1;

  // action codes
  localparam logic [ACTION_BITS-1:0] ACT_PUSH  = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_READ  = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_CLEAR = 2'd2;

  // base characters and their 2-bit codes
  localparam logic [CHAR_BITS-1:0] CHAR_A = 8'h41;
  localparam logic [CHAR_BITS-1:0] CHAR_C = 8'h43;
  localparam logic [CHAR_BITS-1:0] CHAR_G = 8'h47;
  localparam logic [CHAR_BITS-1:0] CHAR_T = 8'h54;
  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic push;         // apply a base to the window, fetch its counter
    logic inc_write;    // write back the incremented counter
    logic read_start;   // fetch the entry at the read cursor
    logic scan;         // fetch the next entry of a scan
    logic clear_start;  // empty window and cursor, restart the sweep
    logic sweep;        // zero one table entry
    logic cap_none;     // capture an exhausted read-out
    logic cap_entry;    // capture the fetched entry as the result
    logic finish;       // settle last_entry from the look-ahead fetch
    logic load_out;     // move the result into the output register
  } akh_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [ACTION_BITS-1:0] action;
    logic push_counts;  // pushed base completes a k-mer
    logic sweep_done;   // last table entry is being zeroed
    logic tag_valid;    // fetched data belongs to a code inside the table
    logic tag_hit;      // fetched data is valid and nonzero
    logic anchor;       // report every code
  } akh_status_t;

  // clamp a table counter to the width of the count port
  function automatic logic [KMER_COUNT_BITS-1:0] count_to_port(
    input logic [COUNT_BITS-1:0] c
  );
    logic [SAT_CMP_BITS-1:0] wide;
    wide = SAT_CMP_BITS'(c);
    if (wide > SAT_CMP_BITS'({KMER_COUNT_BITS{1'b1}})) begin
      return {KMER_COUNT_BITS{1'b1}};
    end
    return KMER_COUNT_BITS'(wide);
  endfunction

endpackage
`default_nettype wire

@@ rtl/akh_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// akh_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module akh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/akh_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// akh_ctrl
// Controller: sequences table clearing, counter updates, read-out scans and
// the output register handshake.
// ----------------------------------------------------------------------------
module akh_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire akh_pkg::akh_status_t st,
  output akh_pkg::akh_cmd_t        cmd
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_INC   = 6'b000100,
    S_SCAN1 = 6'b001000,
    S_SCAN2 = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (st.sweep_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          case (st.action)
            akh_pkg::ACT_PUSH: begin
              cmd.push = 1'b1;
              if (st.push_counts) begin
                state_next = S_INC;
              end
            end
            akh_pkg::ACT_READ: begin
              cmd.read_start = 1'b1;
              state_next     = S_SCAN1;
            end
            akh_pkg::ACT_CLEAR: begin
              cmd.clear_start = 1'b1;
              state_next      = S_CLEAR;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_INC: begin
        cmd.inc_write = 1'b1;
        state_next    = S_IDLE;
      end
      // look for the entry to report
      S_SCAN1: begin
        cmd.scan = 1'b1;
        if (!st.tag_valid) begin
          cmd.cap_none = 1'b1;
          state_next   = S_EMIT;
        end else if (st.anchor || st.tag_hit) begin
          cmd.cap_entry = 1'b1;
          state_next    = st.anchor ? S_EMIT : S_SCAN2;
        end
      end
      // look ahead for another nonzero entry
      S_SCAN2: begin
        cmd.scan = 1'b1;
        if (!st.tag_valid || st.tag_hit) begin
          cmd.finish = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // state register, reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ rtl/akh_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// akh_datapath
// Datapath: base window, configuration registers, count table, read cursor,
// scan address tracking, result and output registers.
// ----------------------------------------------------------------------------
module akh_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [akh_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [akh_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
  input  wire logic [akh_pkg::ACTION_BITS-1:0]       action,
  input  wire logic [akh_pkg::CHAR_BITS-1:0]         base_char,
  input  wire akh_pkg::akh_cmd_t                     cmd,
  output akh_pkg::akh_status_t                       st,
  output logic      [akh_pkg::KMER_CODE_BITS-1:0]    kmer_code,
  output logic      [akh_pkg::KMER_COUNT_BITS-1:0]   kmer_count,
  output logic                                       last_entry,
  output logic                                       none_found
);

  // configuration
  logic [akh_pkg::LEN_BITS-1:0]    kmer_length;
  logic                            anchor_all;
  // window
  logic [akh_pkg::CODE_BITS-1:0]   base_window;
  logic [akh_pkg::FILL_BITS-1:0]   bases_in_window;
  // table access
  logic [akh_pkg::CODE_BITS-1:0]   inc_addr;
  logic [akh_pkg::CODE_BITS-1:0]   sweep_addr;
  logic [akh_pkg::CURSOR_BITS-1:0] read_cursor;
  logic [akh_pkg::CURSOR_BITS-1:0] scan_addr;
  logic [akh_pkg::CURSOR_BITS-1:0] tag;
  logic                            tag_valid;
  // captured result
  logic [akh_pkg::CODE_BITS-1:0]   res_code;
  logic [akh_pkg::COUNT_BITS-1:0]  res_count;
  logic                            res_last;
  logic                            res_none;

  logic [akh_pkg::LEN_BITS-1:0]    eff_len;
  logic [akh_pkg::CURSOR_BITS-1:0] code_limit;
  logic [akh_pkg::CODE_BITS-1:0]   code_mask;
  logic [1:0]                      base_val;
  logic                            base_ok;
  logic [akh_pkg::FILL_BITS-1:0]   fill_next;
  logic [akh_pkg::CODE_BITS-1:0]   window_next;
  logic [akh_pkg::CODE_BITS-1:0]   push_idx;
  logic                            push_counts;
  logic [akh_pkg::CURSOR_BITS-1:0] issue_addr;
  logic                            issue_ok;
  logic                            issue;

  logic                            ram_wr_en;
  logic [akh_pkg::CODE_BITS-1:0]   ram_wr_addr;
  logic [akh_pkg::COUNT_BITS-1:0]  ram_wr_data;
  logic                            ram_rd_en;
  logic [akh_pkg::CODE_BITS-1:0]   ram_rd_addr;
  logic [akh_pkg::COUNT_BITS-1:0]  ram_rd_data;
  logic [akh_pkg::COUNT_BITS-1:0]  inc_value;

  // effective k-mer length and code range
  always_comb begin
    if (kmer_length == '0) begin
      eff_len = akh_pkg::LEN_BITS'(1);
    end else if (kmer_length > akh_pkg::LEN_BITS'(akh_pkg::MAX_KMER_LENGTH)) begin
      eff_len = akh_pkg::LEN_BITS'(akh_pkg::MAX_KMER_LENGTH);
    end else begin
      eff_len = kmer_length;
    end
  end

  assign code_limit = akh_pkg::CURSOR_BITS'(1) << {eff_len, 1'b0};
  assign code_mask  = akh_pkg::CODE_BITS'(code_limit - akh_pkg::CURSOR_BITS'(1));

  // base character decode
  always_comb begin
    base_ok = 1'b1;
    case (base_char)
      akh_pkg::CHAR_A: base_val = akh_pkg::BASE_A;
      akh_pkg::CHAR_C: base_val = akh_pkg::BASE_C;
      akh_pkg::CHAR_G: base_val = akh_pkg::BASE_G;
      akh_pkg::CHAR_T: base_val = akh_pkg::BASE_T;
      default: begin
        base_val = akh_pkg::BASE_A;
        base_ok  = 1'b0;
      end
    endcase
  end

  // window after a push and the counter it selects
  assign fill_next   = (bases_in_window < akh_pkg::FILL_BITS'(akh_pkg::MAX_KMER_LENGTH))
                       ? bases_in_window + akh_pkg::FILL_BITS'(1) : bases_in_window;
  assign window_next = akh_pkg::CODE_BITS'({base_window, base_val});
  assign push_idx    = window_next & code_mask;
  assign push_counts = base_ok && (akh_pkg::LEN_BITS'(fill_next) >= eff_len);

  // read-out fetch address
  assign issue      = cmd.read_start || cmd.scan;
  assign issue_addr = cmd.read_start ? read_cursor : scan_addr;
  assign issue_ok   = issue_addr < code_limit;

  // saturating increment
  assign inc_value = (ram_rd_data == {akh_pkg::COUNT_BITS{1'b1}})
                     ? ram_rd_data : ram_rd_data + akh_pkg::COUNT_BITS'(1);

  // table port selection
  assign ram_wr_en   = cmd.sweep || cmd.inc_write;
  assign ram_wr_addr = cmd.sweep ? sweep_addr : inc_addr;
  assign ram_wr_data = cmd.sweep ? '0 : inc_value;
  assign ram_rd_en   = cmd.push ? push_counts : (issue && issue_ok);
  assign ram_rd_addr = cmd.push ? push_idx : issue_addr[akh_pkg::CODE_BITS-1:0];

  akh_ram #(
    .WIDTH (akh_pkg::COUNT_BITS),
    .DEPTH (akh_pkg::TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // status
  assign st.action      = action;
  assign st.push_counts = push_counts;
  assign st.sweep_done  = (sweep_addr == {akh_pkg::CODE_BITS{1'b1}});
  assign st.tag_valid   = tag_valid;
  assign st.tag_hit     = tag_valid && (ram_rd_data != '0);
  assign st.anchor      = anchor_all;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length <= akh_pkg::KMER_LENGTH_RESET;
      anchor_all  <= akh_pkg::ANCHOR_ALL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        akh_pkg::REG_KMER_LENGTH: kmer_length <= cfg_wdata;
        akh_pkg::REG_ANCHOR_ALL:  anchor_all  <= cfg_wdata[0];
        default: begin
          kmer_length <= kmer_length;
        end
      endcase
    end
  end

  // window, fill level, read cursor and sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      base_window     <= '0;
      bases_in_window <= '0;
      read_cursor     <= '0;
      sweep_addr      <= '0;
    end else begin
      if (cmd.clear_start) begin
        base_window     <= '0;
        bases_in_window <= '0;
        read_cursor     <= '0;
        sweep_addr      <= '0;
      end else begin
        if (cmd.push) begin
          base_window     <= base_ok ? window_next : '0;
          bases_in_window <= base_ok ? fill_next : '0;
        end
        if (cmd.cap_none) begin
          read_cursor <= code_limit;
        end else if (cmd.cap_entry) begin
          read_cursor <= tag + akh_pkg::CURSOR_BITS'(1);
        end
        if (cmd.sweep) begin
          sweep_addr <= sweep_addr + akh_pkg::CODE_BITS'(1);
        end
      end
    end
  end

  // fetch tracking for the read-out scan
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_valid <= 1'b0;
    end else if (issue) begin
      tag_valid <= issue_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      tag       <= issue_addr;
      scan_addr <= issue_addr + akh_pkg::CURSOR_BITS'(1);
    end
    if (cmd.push) begin
      inc_addr <= push_idx;
    end
  end

  // captured result
  always_ff @(posedge clk) begin
    if (cmd.cap_none) begin
      res_code  <= '0;
      res_count <= '0;
      res_last  <= 1'b1;
      res_none  <= 1'b1;
    end else if (cmd.cap_entry) begin
      res_code  <= tag[akh_pkg::CODE_BITS-1:0];
      res_count <= ram_rd_data;
      res_last  <= (tag == code_limit - akh_pkg::CURSOR_BITS'(1));
      res_none  <= 1'b0;
    end else if (cmd.finish) begin
      res_last  <= !tag_valid;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      kmer_code  <= akh_pkg::KMER_CODE_BITS'(res_code);
      kmer_count <= akh_pkg::count_to_port(res_count);
      last_entry <= res_last;
      none_found <= res_none;
    end
  end

endmodule
`default_nettype wire

@@ rtl/anchored_kmer_histogram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// anchored_kmer_histogram
// DNA k-mer counter with a 65536-entry count table and entry read-out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries action and base_char: push a
//   base, read the next table entry, or clear. Only reads give a result on
//   the output channel (out_valid/out_ready). Configuration (kmer_length,
//   anchor_all) is to be written through cfg_we/cfg_index/cfg_wdata only
//   while idle; the user must keep to this, the block does not enforce it.
//   Push: a base that completes a k-mer has its counter read from the
//   table, then written back incremented in S_INC.
//   Read, anchored: the entry at the cursor is fetched, captured in S_SCAN1
//   and loaded into the output register in S_EMIT.
//   Read, unanchored: the table is scanned one entry per cycle from the
//   cursor up to the next nonzero entry and on to the one after it (or to
//   the end of the range).
//   Clear and reset: the table is zeroed by a sweep over all 65536
//   entries, one entry per cycle; in_ready stays low until it is done.
//   A stalled receiver holds the result in the output register; pushes and
//   clears are still taken, a further read is taken too but keeps in_ready
//   low until the register frees.
// ----------------------------------------------------------------------------
module anchored_kmer_histogram (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [akh_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [akh_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [akh_pkg::ACTION_BITS-1:0]       action,
  input  wire logic [akh_pkg::CHAR_BITS-1:0]         base_char,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic      [akh_pkg::KMER_CODE_BITS-1:0]    kmer_code,
  output logic      [akh_pkg::KMER_COUNT_BITS-1:0]   kmer_count,
  output logic                                       last_entry,
  output logic                                       none_found
);

  akh_pkg::akh_cmd_t    cmd;
  akh_pkg::akh_status_t st;

  // controller
  akh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // datapath
  akh_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .action     (action),
    .base_char  (base_char),
    .cmd        (cmd),
    .st         (st),
    .kmer_code  (kmer_code),
    .kmer_count (kmer_count),
    .last_entry (last_entry),
    .none_found (none_found)
  );

endmodule
`default_nettype wire

@@ rtl/akh_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// akh_checker
// Port-level checks for the k-mer histogram block, bound to the top level.
// ----------------------------------------------------------------------------
module akh_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic [akh_pkg::ACTION_BITS-1:0]     action,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic [akh_pkg::KMER_CODE_BITS-1:0]  kmer_code,
  input wire logic [akh_pkg::KMER_COUNT_BITS-1:0] kmer_count,
  input wire logic                                last_entry,
  input wire logic                                none_found
);

  // table sweep holds off input right after reset
  a_busy_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input accepted while table is being cleared");

  // a stalled result transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(kmer_code) && $stable(kmer_count) &&
       $stable(last_entry) && $stable(none_found)))
    else $error("result changed while stalled");

  // pushes and clears produce no result
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action != akh_pkg::ACT_READ) |=> !$rose(out_valid))
    else $error("result appeared after a push or clear");

  // a read keeps the block busy on the following cycle
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action == akh_pkg::ACT_READ) |=> !in_ready)
    else $error("input accepted during a read");

  // an exhausted read-out reports an empty final entry
  a_none_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && none_found) |-> (last_entry && kmer_code == '0 && kmer_count == '0))
    else $error("malformed exhausted read-out result");

endmodule

bind anchored_kmer_histogram akh_checker u_akh_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .action     (action),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .kmer_code  (kmer_code),
  .kmer_count (kmer_count),
  .last_entry (last_entry),
  .none_found (none_found)
);
`default_nettype wire
